>>> rtl/core/impulse_noise_median_filter_assert.svh
// assertion macros for the impulse noise median filter
// expects clk and rst_n in the scope of the including module
`ifndef IMPULSE_NOISE_MEDIAN_FILTER_ASSERT_SVH
`define IMPULSE_NOISE_MEDIAN_FILTER_ASSERT_SVH

// same-cycle implication
`define INMF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("inmf assertion failed in %m");

// next-cycle implication
`define INMF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("inmf assertion failed in %m");

`endif

>>> rtl/core/inmf_pkg.sv
// shared constants, types and register codes of the impulse noise median filter
// no dependencies
`default_nettype none

package inmf_pkg;

  localparam int unsigned MAX_WIDTH    = 1024;
  localparam int unsigned MAX_HEIGHT   = 4096;

  localparam int unsigned PIX_W        = 8;
  localparam int unsigned COL_W        = $clog2(MAX_WIDTH);
  localparam int unsigned OUT_ROW_W    = $clog2(MAX_HEIGHT);
  localparam int unsigned ROW_W        = OUT_ROW_W + 1;
  localparam int unsigned CFG_WIDTH_W  = 11;
  localparam int unsigned CFG_HEIGHT_W = 13;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam int unsigned CELLS        = 9;
  localparam int unsigned CENTRE       = 4;
  localparam int unsigned NBR          = 8;

  localparam int unsigned FIFO_DEPTH   = 8;
  localparam int unsigned FIFO_AW      = $clog2(FIFO_DEPTH);

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = CFG_WIDTH_W'(640);
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = CFG_HEIGHT_W'(480);

  localparam logic [PIX_W-1:0] PIX_BLACK = PIX_W'(0);
  localparam logic [PIX_W-1:0] PIX_WHITE = PIX_W'(255);

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [CELLS-1:0] win_t;
  typedef logic [NBR-1:0]   nbr_mask_t;

  typedef struct packed {
    logic [COL_W-1:0]     col;
    logic [OUT_ROW_W-1:0] row;
    logic                 last;
    nbr_mask_t            mask;
  } meta_t;

  typedef struct packed {
    pix_t                 pix;
    logic [COL_W-1:0]     col;
    logic [OUT_ROW_W-1:0] row;
    logic                 last;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/inmf_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
`default_nettype none

module inmf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/inmf_median.sv
// impulse test and masked median of the eight window neighbours, two stages
// depends on inmf_pkg
`default_nettype none

module inmf_median (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_vld,
  input  wire inmf_pkg::win_t  win,
  input  wire inmf_pkg::meta_t meta,
  output logic                 res_vld,
  output inmf_pkg::res_t       res,
  output logic [1:0]           stage_vld
);

  typedef logic [inmf_pkg::PIX_W:0] key_t;
  typedef key_t [inmf_pkg::NBR-1:0] key_vec_t;

  function automatic key_vec_t cas(input key_vec_t v, input logic [2:0] a,
                                   input logic [2:0] b);
    key_vec_t o;
    o = v;
    if (v[a] > v[b]) begin
      o[a] = v[b];
      o[b] = v[a];
    end
    return o;
  endfunction

  key_vec_t        keys;
  key_vec_t        a_keys;
  key_vec_t        b_keys;
  logic [3:0]      n_valid;
  logic            pass;

  logic            a_vld_r;
  key_vec_t        a_keys_r;
  inmf_pkg::pix_t  a_centre_r;
  logic [2:0]      a_idx_r;
  logic            a_pass_r;
  inmf_pkg::meta_t a_meta_r;

  logic            b_vld_r;
  inmf_pkg::res_t  b_res_r;
  inmf_pkg::res_t  b_res_nxt;

  // out-of-image neighbours get the top key bit and sort to the end
  always_comb begin
    keys[0] = {~meta.mask[0], win[0]};
    keys[1] = {~meta.mask[1], win[1]};
    keys[2] = {~meta.mask[2], win[2]};
    keys[3] = {~meta.mask[3], win[3]};
    keys[4] = {~meta.mask[4], win[5]};
    keys[5] = {~meta.mask[5], win[6]};
    keys[6] = {~meta.mask[6], win[7]};
    keys[7] = {~meta.mask[7], win[8]};
    n_valid = 4'($countones(meta.mask));
    pass = ((win[inmf_pkg::CENTRE] != inmf_pkg::PIX_BLACK) &&
            (win[inmf_pkg::CENTRE] != inmf_pkg::PIX_WHITE)) || (n_valid == 4'd0);

    a_keys = keys;
    a_keys = cas(a_keys, 3'd0, 3'd1);
    a_keys = cas(a_keys, 3'd2, 3'd3);
    a_keys = cas(a_keys, 3'd4, 3'd5);
    a_keys = cas(a_keys, 3'd6, 3'd7);
    a_keys = cas(a_keys, 3'd0, 3'd2);
    a_keys = cas(a_keys, 3'd1, 3'd3);
    a_keys = cas(a_keys, 3'd4, 3'd6);
    a_keys = cas(a_keys, 3'd5, 3'd7);
    a_keys = cas(a_keys, 3'd1, 3'd2);
    a_keys = cas(a_keys, 3'd5, 3'd6);
  end

  always_comb begin
    b_keys = a_keys_r;
    b_keys = cas(b_keys, 3'd0, 3'd4);
    b_keys = cas(b_keys, 3'd1, 3'd5);
    b_keys = cas(b_keys, 3'd2, 3'd6);
    b_keys = cas(b_keys, 3'd3, 3'd7);
    b_keys = cas(b_keys, 3'd2, 3'd4);
    b_keys = cas(b_keys, 3'd3, 3'd5);
    b_keys = cas(b_keys, 3'd1, 3'd2);
    b_keys = cas(b_keys, 3'd3, 3'd4);
    b_keys = cas(b_keys, 3'd5, 3'd6);

    b_res_nxt.pix  = a_pass_r ? a_centre_r : b_keys[a_idx_r][inmf_pkg::PIX_W-1:0];
    b_res_nxt.col  = a_meta_r.col;
    b_res_nxt.row  = a_meta_r.row;
    b_res_nxt.last = a_meta_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
    end
    a_keys_r   <= a_keys;
    a_centre_r <= win[inmf_pkg::CENTRE];
    a_idx_r    <= n_valid[3:1];
    a_pass_r   <= pass;
    a_meta_r   <= meta;
    b_res_r    <= b_res_nxt;
  end

  assign res_vld   = b_vld_r;
  assign res       = b_res_r;
  assign stage_vld = {b_vld_r, a_vld_r};

endmodule

`default_nettype wire

>>> rtl/core/impulse_noise_median_filter.sv
// Switching 3x3 median filter for 8-bit grey pixels in raster order. One beat is
// accepted per clock; in_ready drops only when the 8-entry result buffer backs up.
// A pixel of 0 or 255 is replaced by the median of its in-image neighbours.
// The result for a pixel leaves image_width+1 beats after it enters (send
// image_width+1 drain beats after a frame). After the due beat is accepted, out_valid
// rises once it has passed the row-store read on the accepting edge, then the window
// update, two sorting-network stages and the result buffer. Both row
// stores share one 1024x16 ram read and written once per beat; back-to-back
// beats on the same column are forwarded. No clearing pass after reset.
// depends on inmf_pkg, inmf_ram, inmf_median, impulse_noise_median_filter_assert.svh
`default_nettype none

`include "impulse_noise_median_filter_assert.svh"

module impulse_noise_median_filter (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_mode,
  input  wire logic [inmf_pkg::PIX_W-1:0]      in_pixel_in,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [inmf_pkg::PIX_W-1:0]           out_pixel_out,
  output logic [inmf_pkg::COL_W-1:0]           out_column,
  output logic [inmf_pkg::OUT_ROW_W-1:0]       out_row,
  output logic                                 out_frame_last,
  input  wire logic                            cfg_wr_en,
  input  wire logic [inmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [inmf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned RAM_W = 2 * inmf_pkg::PIX_W;
  localparam int unsigned OCC_W = inmf_pkg::FIFO_AW + 2;

  logic [inmf_pkg::CFG_WIDTH_W-1:0]  width_r;
  logic [inmf_pkg::CFG_HEIGHT_W-1:0] height_r;
  logic [inmf_pkg::COL_W-1:0]        w_m1;
  logic [inmf_pkg::OUT_ROW_W-1:0]    h_m1;

  logic [inmf_pkg::COL_W-1:0]        col_r;
  logic [inmf_pkg::COL_W-1:0]        col_nxt;
  logic [inmf_pkg::ROW_W-1:0]        row_r;
  logic [inmf_pkg::ROW_W-1:0]        row_nxt;

  logic                              accept;
  logic                              pix_phase;
  logic                              take;
  inmf_pkg::pix_t                    val;
  logic                              emit;
  logic [inmf_pkg::COL_W-1:0]        ox;
  logic [inmf_pkg::ROW_W-1:0]        oy;
  logic                              up_ok;
  logic                              dn_ok;
  logic                              lf_ok;
  logic                              rt_ok;
  inmf_pkg::meta_t                   meta;

  logic                              s1_vld_r;
  logic                              s1_emit_r;
  logic [inmf_pkg::COL_W-1:0]        s1_addr_r;
  inmf_pkg::pix_t                    s1_val_r;
  inmf_pkg::meta_t                   s1_meta_r;
  logic                              fwd_r;
  logic [RAM_W-1:0]                  fwd_data_r;
  logic [RAM_W-1:0]                  ram_rdata;
  logic [RAM_W-1:0]                  rd;
  logic [RAM_W-1:0]                  wdata;

  inmf_pkg::win_t                    win_r;
  inmf_pkg::win_t                    win_base;
  inmf_pkg::win_t                    win_nxt;
  logic                              clr_pend_r;

  logic                              s2_emit_r;
  inmf_pkg::meta_t                   s2_meta_r;

  logic                              res_vld;
  inmf_pkg::res_t                    res;
  logic [1:0]                        med_vld;

  inmf_pkg::res_t                    fifo_r [inmf_pkg::FIFO_DEPTH];
  logic [inmf_pkg::FIFO_AW-1:0]      head_r;
  logic [inmf_pkg::FIFO_AW-1:0]      tail_r;
  logic [inmf_pkg::FIFO_AW:0]        cnt_r;
  logic                              pop;
  logic [OCC_W-1:0]                  occ;

  // effective frame size, clamped
  always_comb begin
    if (width_r == '0) begin
      w_m1 = '0;
    end else if (width_r > inmf_pkg::CFG_WIDTH_W'(inmf_pkg::MAX_WIDTH)) begin
      w_m1 = inmf_pkg::COL_W'(inmf_pkg::MAX_WIDTH - 1);
    end else begin
      w_m1 = inmf_pkg::COL_W'(width_r - 1'b1);
    end
    if (height_r == '0) begin
      h_m1 = '0;
    end else if (height_r > inmf_pkg::CFG_HEIGHT_W'(inmf_pkg::MAX_HEIGHT)) begin
      h_m1 = inmf_pkg::OUT_ROW_W'(inmf_pkg::MAX_HEIGHT - 1);
    end else begin
      h_m1 = inmf_pkg::OUT_ROW_W'(height_r - 1'b1);
    end
  end

  // position and border flags of the pixel leaving the window
  always_comb begin
    accept    = in_valid && in_ready;
    pix_phase = row_r <= inmf_pkg::ROW_W'(h_m1);
    take      = accept && !(pix_phase && in_mode);
    val       = pix_phase ? in_pixel_in : inmf_pkg::PIX_BLACK;
    emit      = !((row_r == '0) || ((row_r == inmf_pkg::ROW_W'(1)) && (col_r == '0)));
    if (col_r == '0) begin
      ox = w_m1;
      oy = row_r - inmf_pkg::ROW_W'(2);
    end else begin
      ox = col_r - 1'b1;
      oy = row_r - 1'b1;
    end
    up_ok = oy != '0;
    dn_ok = oy < inmf_pkg::ROW_W'(h_m1);
    lf_ok = ox != '0;
    rt_ok = ox < w_m1;
    meta.col     = ox;
    meta.row     = oy[inmf_pkg::OUT_ROW_W-1:0];
    meta.last    = emit && (ox == w_m1) && (oy == inmf_pkg::ROW_W'(h_m1));
    meta.mask[0] = up_ok && lf_ok;
    meta.mask[1] = up_ok;
    meta.mask[2] = up_ok && rt_ok;
    meta.mask[3] = lf_ok;
    meta.mask[4] = rt_ok;
    meta.mask[5] = dn_ok && lf_ok;
    meta.mask[6] = dn_ok;
    meta.mask[7] = dn_ok && rt_ok;

    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr_en || (take && meta.last)) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (take) begin
      if (col_r == w_m1) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  // row store: upper in the high byte, middle in the low byte
  always_comb begin
    rd       = fwd_r ? fwd_data_r : ram_rdata;
    wdata    = {rd[inmf_pkg::PIX_W-1:0], s1_val_r};
    win_base = clr_pend_r ? '0 : win_r;
    win_nxt[0] = win_base[1];
    win_nxt[1] = win_base[2];
    win_nxt[2] = rd[RAM_W-1:inmf_pkg::PIX_W];
    win_nxt[3] = win_base[4];
    win_nxt[4] = win_base[5];
    win_nxt[5] = rd[inmf_pkg::PIX_W-1:0];
    win_nxt[6] = win_base[7];
    win_nxt[7] = win_base[8];
    win_nxt[8] = s1_val_r;
  end

  inmf_ram #(
    .WIDTH (RAM_W),
    .DEPTH (inmf_pkg::MAX_WIDTH)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (s1_vld_r),
    .wr_addr (s1_addr_r),
    .wr_data (wdata),
    .rd_en   (take),
    .rd_addr (col_r),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= inmf_pkg::WIDTH_RESET;
      height_r   <= inmf_pkg::HEIGHT_RESET;
      col_r      <= '0;
      row_r      <= '0;
      s1_vld_r   <= 1'b0;
      s1_emit_r  <= 1'b0;
      fwd_r      <= 1'b0;
      clr_pend_r <= 1'b1;
      s2_emit_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          inmf_pkg::CFG_IMAGE_WIDTH: begin
            width_r <= cfg_wdata[inmf_pkg::CFG_WIDTH_W-1:0];
          end
          inmf_pkg::CFG_IMAGE_HEIGHT: begin
            height_r <= cfg_wdata[inmf_pkg::CFG_HEIGHT_W-1:0];
          end
        endcase
      end
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      s1_vld_r  <= take;
      s1_emit_r <= take && emit;
      fwd_r     <= take && s1_vld_r && (s1_addr_r == col_r);
      if (cfg_wr_en) begin
        clr_pend_r <= 1'b1;
      end else if (s1_vld_r) begin
        clr_pend_r <= s1_meta_r.last;
      end
      s2_emit_r <= s1_emit_r;
    end
    if (take) begin
      s1_addr_r  <= col_r;
      s1_val_r   <= val;
      s1_meta_r  <= meta;
      fwd_data_r <= wdata;
    end
    if (s1_vld_r) begin
      win_r <= win_nxt;
    end
    s2_meta_r <= s1_meta_r;
  end

  inmf_median u_median (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (s2_emit_r),
    .win       (win_r),
    .meta      (s2_meta_r),
    .res_vld   (res_vld),
    .res       (res),
    .stage_vld (med_vld)
  );

  // result buffer, space reserved for every beat in flight
  assign pop = out_valid && out_ready;
  assign occ = OCC_W'(cnt_r) + OCC_W'(s1_emit_r) + OCC_W'(s2_emit_r)
             + OCC_W'(med_vld[0]) + OCC_W'(med_vld[1]);
  assign in_ready = occ < OCC_W'(inmf_pkg::FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (res_vld) begin
        tail_r <= tail_r + 1'b1;
      end
      if (pop) begin
        head_r <= head_r + 1'b1;
      end
      if (res_vld && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!res_vld && pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (res_vld) begin
      fifo_r[tail_r] <= res;
    end
  end

  assign out_valid      = cnt_r != '0;
  assign out_pixel_out  = fifo_r[head_r].pix;
  assign out_column     = fifo_r[head_r].col;
  assign out_row        = fifo_r[head_r].row;
  assign out_frame_last = fifo_r[head_r].last;

  `INMF_ASSERT_IMPL(a_no_overflow, res_vld && !pop, !cnt_r[inmf_pkg::FIFO_AW])
  `INMF_ASSERT_IMPL(a_fwd_needs_write, fwd_r, s1_vld_r)
  `INMF_ASSERT_NEXT(a_frame_restart, take && meta.last, (col_r == '0) && (row_r == '0))

endmodule

`default_nettype wire
